// ----- src/sfce_pkg.sv -----
`default_nettype none
package sfce_pkg;

  localparam int unsigned STORE_DEPTH = 11;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned MAX_PAY     = 5;
  localparam int unsigned PAY_CNT_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_LASER   = 8'h5A;
  localparam logic [7:0] HDR_LASER_2 = 8'h15;
  localparam logic [7:0] TYPE_04     = 8'h04;
  localparam logic [7:0] TYPE_03     = 8'h03;
  localparam logic [7:0] HDR_LIGHT_0 = 8'h4C;
  localparam logic [7:0] HDR_LIGHT_1 = 8'h3A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] HDR_ULTRA   = 8'hFF;

  localparam logic [1:0] KIND_LASER04 = 2'd0;
  localparam logic [1:0] KIND_LASER03 = 2'd1;
  localparam logic [1:0] KIND_LIGHT   = 2'd2;
  localparam logic [1:0] KIND_ULTRA   = 2'd3;

  localparam logic [PAY_CNT_W-1:0] LEN_SHORT = PAY_CNT_W'(2);
  localparam logic [PAY_CNT_W-1:0] LEN_LIGHT = PAY_CNT_W'(MAX_PAY);

  typedef logic [7:0] byte_t;

  // One checked frame: its kind, how many payload bytes and the bytes.
  typedef struct packed {
    logic [1:0]                kind;
    logic [PAY_CNT_W-1:0]      len;
    logic [MAX_PAY-1:0][7:0]   pay;
  } frame_desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage
`default_nettype wire

// ----- src/sfce_front.sv -----
`default_nettype none
module sfce_front
  import sfce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_has_byte,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_end,
  output logic             in_stall,
  input  wire queue_stat_t q_stat,
  output logic             push,
  output frame_desc_t      push_desc
);

  byte_t            store_r [STORE_DEPTH];
  byte_t            store_nxt [STORE_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  byte_t            sum3_r, sum7_r, sum8_r;
  byte_t            sum3_nxt, sum7_nxt, sum8_nxt;

  logic accept;
  logic wr;
  logic laser_hdr, m04, m03, mlight, multra;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign wr       = in_has_byte && (cnt_r < CNT_W'(STORE_DEPTH));

  // The store as it looks with this request's byte written in; the frame
  // check works on this view so a byte and the frame end may share a request.
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      store_nxt[k] = (wr && cnt_r == CNT_W'(k)) ? in_data_byte : store_r[k];
    end
    sum3_nxt = sum3_r + ((wr && cnt_r < CNT_W'(3)) ? in_data_byte : 8'h00);
    sum7_nxt = sum7_r + ((wr && cnt_r < CNT_W'(7)) ? in_data_byte : 8'h00);
    sum8_nxt = sum8_r + ((wr && cnt_r < CNT_W'(8)) ? in_data_byte : 8'h00);
    cnt_nxt  = wr ? cnt_r + CNT_W'(1) : cnt_r;
  end

  always_comb begin
    laser_hdr = store_nxt[0] == HDR_LASER && store_nxt[1] == HDR_LASER &&
                store_nxt[2] == HDR_LASER_2;
    m04    = laser_hdr && store_nxt[3] == TYPE_04 && sum8_nxt == store_nxt[8];
    m03    = laser_hdr && store_nxt[3] == TYPE_03 && sum7_nxt == store_nxt[7];
    mlight = store_nxt[0] == HDR_LIGHT_0 && store_nxt[1] == HDR_LIGHT_1 &&
             store_nxt[9] == CHAR_CR && store_nxt[10] == CHAR_LF;
    multra = store_nxt[0] == HDR_ULTRA && sum3_nxt == store_nxt[3];

    push_desc = '0;
    if (m04 || m03) begin
      push_desc.kind   = m04 ? KIND_LASER04 : KIND_LASER03;
      push_desc.len    = LEN_SHORT;
      push_desc.pay[0] = store_nxt[4];
      push_desc.pay[1] = store_nxt[5];
    end else if (mlight) begin
      push_desc.kind = KIND_LIGHT;
      push_desc.len  = LEN_LIGHT;
      for (int i = 0; i < MAX_PAY; i++) begin
        push_desc.pay[i] = store_nxt[i + 2];
      end
    end else if (multra) begin
      push_desc.kind   = KIND_ULTRA;
      push_desc.len    = LEN_SHORT;
      push_desc.pay[0] = store_nxt[1];
      push_desc.pay[1] = store_nxt[2];
    end
    push = accept && in_frame_end && (m04 || m03 || mlight || multra);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum3_r <= '0;
      sum7_r <= '0;
      sum8_r <= '0;
      for (int k = 0; k < STORE_DEPTH; k++) begin
        store_r[k] <= '0;
      end
    end else if (accept) begin
      if (in_frame_end) begin
        cnt_r  <= '0;
        sum3_r <= '0;
        sum7_r <= '0;
        sum8_r <= '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
          store_r[k] <= '0;
        end
      end else begin
        cnt_r  <= cnt_nxt;
        sum3_r <= sum3_nxt;
        sum7_r <= sum7_nxt;
        sum8_r <= sum8_nxt;
        for (int k = 0; k < STORE_DEPTH; k++) begin
          store_r[k] <= store_nxt[k];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/sfce_queue.sv -----
`default_nettype none
module sfce_queue
  import sfce_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire frame_desc_t  push_desc,
  input  wire logic         pop,
  output frame_desc_t       pop_desc,
  output queue_stat_t       q_stat
);

  frame_desc_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign pop_desc     = mem_r[rd_ptr_r];
  assign q_stat.empty = cnt_r == '0;
  assign q_stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/sfce_back.sv -----
`default_nettype none
module sfce_back
  import sfce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire queue_stat_t q_stat,
  input  wire frame_desc_t pop_desc,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_sensor_kind,
  output logic             out_last_of_run,
  input  wire logic        out_stall
);

  frame_desc_t          cur_r;
  logic [PAY_CNT_W-1:0] idx_r;
  logic                 busy_r;
  logic                 take, done;

  assign out_valid        = busy_r;
  assign out_payload_byte = cur_r.pay[idx_r];
  assign out_sensor_kind  = cur_r.kind;
  assign out_last_of_run  = idx_r == cur_r.len - PAY_CNT_W'(1);

  assign take = busy_r && !out_stall;
  assign done = take && out_last_of_run;
  // The next frame is loaded in the cycle the last byte leaves.
  assign pop  = !q_stat.empty && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + PAY_CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- src/sensor_frame_check_extract_unit.sv -----
`default_nettype none
// Channel   Direction  Handshake           Fields
// in_       input      in_valid/in_stall   has_byte, data_byte[7:0], frame_end
// out_      output     out_valid/out_stall payload_byte[7:0], sensor_kind[1:0],
//                                          last_of_run
//
// A byte request is taken every cycle unless stalled; a frame end is checked in
// the cycle it is taken; its payload bytes are offered from the emitter's
// register one per cycle while out_stall is low, with no gap between frames.
// Input stalls only while the two-entry frame queue between checker and
// emitter is full, so it follows the output side's stalls with that slack.
// Reset (rst_n low, synchronous) clears the capture store, count and queue.
module sensor_frame_check_extract_unit
  import sfce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_has_byte,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic [1:0]      out_sensor_kind,
  output logic            out_last_of_run
);

  queue_stat_t q_stat;
  logic        push, pop;
  frame_desc_t push_desc, pop_desc;

  sfce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_has_byte  (in_has_byte),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .in_stall     (in_stall),
    .q_stat       (q_stat),
    .push         (push),
    .push_desc    (push_desc)
  );

  sfce_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  sfce_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_desc         (pop_desc),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_sensor_kind  (out_sensor_kind),
    .out_last_of_run  (out_last_of_run),
    .out_stall        (out_stall)
  );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sfce_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;

  // One byte request as the sender presents it; drain_first makes the sender
  // wait until every expected payload byte has come back before offering it.
  typedef struct packed {
    logic  has_byte;
    byte_t data;
    logic  frame_end;
    logic  drain_first;
  } byte_req_t;

  typedef struct packed {
    byte_t      payload;
    logic [1:0] kind;
    logic       last;
  } payload_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_has_byte = 1'b0;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic [1:0] out_sensor_kind;
  logic       out_last_of_run;

  sensor_frame_check_extract_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_has_byte      (in_has_byte),
    .in_data_byte     (in_data_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_sensor_kind  (out_sensor_kind),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_req_t pending_reqs[$];
  payload_t  payload_exp[$];
  byte_t     frame_buf[$];
  byte_t     cap_bytes[STORE_DEPTH];
  int        cap_count = 0;
  int        errors = 0;
  int        cycle_count = 0;
  int        stim_items = 0;
  bit        drain_next = 1'b0;
  bit        noisy = 1'b0;
  bit        quiet = 1'b0;

  // Frame checker and payload extractor, advanced by one accepted request.
  task automatic capture_and_extract(input byte_req_t r);
    byte_t      s3;
    byte_t      s7;
    byte_t      s8;
    byte_t      pays[MAX_PAY];
    logic [1:0] kind;
    int         n;
    bit         laser_hdr;
    if (r.has_byte && cap_count < STORE_DEPTH) begin
      cap_bytes[cap_count] = r.data;
      cap_count++;
    end
    if (r.frame_end) begin
      s3 = 8'h00;
      s7 = 8'h00;
      s8 = 8'h00;
      n = 0;
      kind = KIND_LASER04;
      for (int k = 0; k < 8; k++) begin
        if (k < 3) s3 += cap_bytes[k];
        if (k < 7) s7 += cap_bytes[k];
        s8 += cap_bytes[k];
      end
      laser_hdr = cap_bytes[0] == HDR_LASER && cap_bytes[1] == HDR_LASER &&
                  cap_bytes[2] == HDR_LASER_2;
      if (laser_hdr && cap_bytes[3] == TYPE_04 && s8 == cap_bytes[8]) begin
        kind = KIND_LASER04;
        pays[0] = cap_bytes[4];
        pays[1] = cap_bytes[5];
        n = 2;
      end else if (laser_hdr && cap_bytes[3] == TYPE_03 && s7 == cap_bytes[7]) begin
        kind = KIND_LASER03;
        pays[0] = cap_bytes[4];
        pays[1] = cap_bytes[5];
        n = 2;
      end else if (cap_bytes[0] == HDR_LIGHT_0 && cap_bytes[1] == HDR_LIGHT_1 &&
                   cap_bytes[9] == CHAR_CR && cap_bytes[10] == CHAR_LF) begin
        kind = KIND_LIGHT;
        for (int k = 0; k < 5; k++) pays[k] = cap_bytes[k + 2];
        n = 5;
      end else if (cap_bytes[0] == HDR_ULTRA && s3 == cap_bytes[3]) begin
        kind = KIND_ULTRA;
        pays[0] = cap_bytes[1];
        pays[1] = cap_bytes[2];
        n = 2;
      end
      for (int k = 0; k < n; k++) payload_exp.push_back('{pays[k], kind, k == n - 1});
      for (int k = 0; k < STORE_DEPTH; k++) cap_bytes[k] = 8'h00;
      cap_count = 0;
    end
  endtask

  task automatic queue_req(input bit has_byte, input byte_t data, input bit frame_end);
    pending_reqs.push_back('{has_byte, data, frame_end, drain_next});
    drain_next = 1'b0;
    if (has_byte || frame_end) stim_items++;
  endtask

  // Sends frame_buf as byte requests, closing the frame either on its last byte
  // or with a separate close-only request.
  task automatic send_frame(input bit broken, input bit merge_end);
    int idx;
    if (broken && frame_buf.size() > 0) begin
      idx = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < frame_buf.size(); i++) begin
      if (noisy && $urandom_range(0, 7) == 0) queue_req(1'b0, 8'($urandom), 1'b0);
      queue_req(1'b1, frame_buf[i], merge_end && i == frame_buf.size() - 1);
    end
    if (!merge_end || frame_buf.size() == 0) queue_req(1'b0, 8'($urandom), 1'b1);
    frame_buf.delete();
  endtask

  // Pads frame_buf with random bytes up to n, then appends their 8-bit sum.
  task automatic add_check_byte(input int n);
    byte_t s;
    s = 8'h00;
    while (frame_buf.size() < n) frame_buf.push_back(8'($urandom));
    foreach (frame_buf[i]) s += frame_buf[i];
    frame_buf.push_back(s);
  endtask

  task automatic build_format(input int fmt);
    case (fmt)
      0: begin
        frame_buf = '{HDR_LASER, HDR_LASER, HDR_LASER_2, TYPE_04};
        add_check_byte(8);
      end
      1: begin
        frame_buf = '{HDR_LASER, HDR_LASER, HDR_LASER_2, TYPE_03};
        add_check_byte(7);
      end
      2: begin
        frame_buf = '{HDR_LIGHT_0, HDR_LIGHT_1};
        repeat (7) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(CHAR_CR);
        frame_buf.push_back(CHAR_LF);
      end
      default: begin
        frame_buf = '{HDR_ULTRA};
        add_check_byte(3);
      end
    endcase
  endtask

  // Sender: holds a stalled request, otherwise offers the next one after any gap.
  byte_req_t cur_req;
  int        src_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) capture_and_extract(cur_req);
      quiet = pending_reqs.size() < 30;
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (!pending_reqs[0].drain_first || (payload_exp.size() == 0 && !in_valid))) begin
        cur_req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_has_byte <= cur_req.has_byte;
        in_data_byte <= cur_req.data;
        in_frame_end <= cur_req.frame_end;
        if (!quiet && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted payload byte and plays the stall pattern.
  payload_t want;
  int       snk_burst = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       results_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (payload_exp.size() == 0) begin
          $display("%0t: unexpected payload byte: expected none, actual %h kind %0d last %b",
                   $time, out_payload_byte, out_sensor_kind, out_last_of_run);
          errors++;
        end else begin
          want = payload_exp.pop_front();
          if (out_payload_byte !== want.payload) begin
            $display("%0t: payload_byte mismatch: expected %h, actual %h",
                     $time, want.payload, out_payload_byte);
            errors++;
          end
          if (out_sensor_kind !== want.kind) begin
            $display("%0t: sensor_kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, out_sensor_kind);
            errors++;
          end
          if (out_last_of_run !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last, out_last_of_run);
            errors++;
          end
        end
      end
      // A single long hold-off lets the frame queue fill so the input side stalls.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (snk_burst > 0) begin
        snk_burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        snk_burst = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d payload bytes outstanding", $time, payload_exp.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int good_frames;
    int frames;
    int pick;
    bit broken;
    for (int k = 0; k < STORE_DEPTH; k++) cap_bytes[k] = 8'h00;

    // Short ultrasonic reply: the missing check byte reads as zero and matches.
    frame_buf = '{HDR_ULTRA, 8'h01};
    send_frame(1'b0, 1'b0);
    // Short laser replies whose zero-filled tails still pass the sum check.
    frame_buf = '{HDR_LASER, HDR_LASER, HDR_LASER_2, TYPE_03, 8'h34};
    send_frame(1'b0, 1'b1);
    frame_buf = '{HDR_LASER, HDR_LASER, HDR_LASER_2, TYPE_04, 8'h33};
    send_frame(1'b0, 1'b1);
    // Overlong light reply: the twelfth byte must be dropped.
    frame_buf = '{HDR_LIGHT_0, HDR_LIGHT_1, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01,
                  8'hAA, 8'h55, CHAR_CR, CHAR_LF, 8'h5A};
    send_frame(1'b0, 1'b1);
    // Empty frame gives no match; a request with neither byte nor end does nothing.
    send_frame(1'b0, 1'b0);
    queue_req(1'b0, 8'h5A, 1'b0);

    noisy = 1'b1;
    drain_next = 1'b1;
    rand_start = stim_items;
    good_frames = 0;
    frames = 0;
    while (stim_items - rand_start < 124 || good_frames < 6) begin
      pick = $urandom_range(0, 9);
      broken = 1'b0;
      if (pick < 8) begin
        build_format(pick / 2);
        broken = $urandom_range(0, 4) == 0;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
        if (!broken) good_frames++;
      end else if (pick == 8) begin
        repeat ($urandom_range(0, 13)) frame_buf.push_back(8'($urandom));
      end else begin
        build_format($urandom_range(0, 3));
        repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
      end
      frames++;
      if (frames == 12) drain_next = 1'b1;
      send_frame(broken, $urandom_range(0, 1));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() > 0 || in_valid || payload_exp.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && payload_exp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
